[sv/lfpsc_pkg.sv]
// shared types, constants and helpers for the line follower speed controller
`default_nettype none

package lfpsc_pkg;

  // field widths
  localparam int SENSE_W   = 10;
  localparam int POS_W     = 13;
  localparam int SPEED_W   = 9;
  localparam int THRESH_W  = 12;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // internal arithmetic widths
  localparam int ERR_W    = 13;
  localparam int INTEG_W  = 16;
  localparam int INC_W    = 11;
  localparam int EFFORT_W = 34;
  localparam int RAW_W    = 35;

  // controller constants
  localparam logic [POS_W-1:0]          POS_MAX       = 13'd5000;
  localparam logic signed [ERR_W:0]     POS_CENTER    = 14'sd1500;
  localparam logic signed [INTEG_W:0]   INTEG_RESET_ABOVE = 17'sd10000;
  localparam logic signed [INTEG_W:0]   INTEG_MIN     = -17'sd32768;
  localparam logic [3:0]                CENTER_LIMIT  = 4'd8;
  localparam logic [2:0]                OFF_LIMIT     = 3'd4;
  localparam logic signed [INC_W-1:0]   INC_MAX       = 11'sd1023;
  localparam logic signed [INC_W-1:0]   INC_MIN       = 11'h400;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH_RIGHT = 3'd0,
    REG_THRESH_LEFT  = 3'd1,
    REG_GAIN_P       = 3'd2,
    REG_GAIN_I       = 3'd3,
    REG_GAIN_D       = 3'd4,
    REG_CRUISE_SPEED = 3'd5,
    REG_SLOW_SPEED   = 3'd6,
    REG_SPEED_CAP    = 3'd7
  } reg_index_t;

  // input beat
  typedef struct packed {
    logic [SENSE_W-1:0] sense_a;
    logic [SENSE_W-1:0] sense_b;
    logic [SENSE_W-1:0] sense_c;
    logic [SENSE_W-1:0] sense_d;
    logic [SENSE_W-1:0] sense_e;
    logic [SENSE_W-1:0] sense_f;
    logic [POS_W-1:0]   line_position;
    logic               near_obstacle;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               at_intersection;
  } out_beat_t;

  // pid gains, unsigned q0.16
  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_i;
    logic [GAIN_W-1:0] gain_d;
  } pid_gains_t;

  // full register set
  typedef struct packed {
    logic [THRESH_W-1:0] thresh_right;
    logic [THRESH_W-1:0] thresh_left;
    pid_gains_t          gains;
    logic [SPEED_W-1:0]  cruise_speed;
    logic [SPEED_W-1:0]  slow_speed;
    logic [SPEED_W-1:0]  speed_cap;
  } cfg_regs_t;

  localparam cfg_regs_t CFG_RESET = '{
    thresh_right: 12'd4095,
    thresh_left:  12'd4095,
    gains:        '{gain_p: 16'd5243, gain_i: 16'd7, gain_d: 16'd24576},
    cruise_speed: 9'd300,
    slow_speed:   9'd100,
    speed_cap:    9'd420
  };

  // per-sample control into the speed ramp
  typedef struct packed {
    logic centered;
    logic near;
  } ramp_ctl_t;

  // floor a q16 level to an integer speed and clamp it to 0..top
  function automatic logic [SPEED_W-1:0] clamp_speed(input logic signed [RAW_W-1:0] q16,
                                                     input logic [SPEED_W-1:0] top);
    logic [SPEED_W-1:0] res;
    if (q16 < 0) begin
      res = '0;
    end else if (q16[RAW_W-1:16] > (RAW_W-16)'(top)) begin
      res = top;
    end else begin
      res = q16[16+SPEED_W-1:16];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/lfpsc_ramp.sv]
// speed increment ramp driven by centered and off-center sample runs
`default_nettype none

module lfpsc_ramp
  import lfpsc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    step,
  input  wire ramp_ctl_t               ctl,
  output logic signed [INC_W-1:0]      incr_next
);

  logic [3:0]              centered_count, centered_count_next;
  logic [2:0]              off_count, off_count_next;
  logic signed [INC_W-1:0] speed_increment;
  logic [3:0]              centered_inc;
  logic [2:0]              off_inc;
  logic signed [INC_W-1:0] ramped;

  assign centered_inc = centered_count + 4'd1;
  assign off_inc      = off_count + 3'd1;

  // run counters and saturating step of the increment
  always_comb begin
    centered_count_next = centered_count;
    off_count_next      = off_count;
    ramped              = speed_increment;
    if (ctl.centered) begin
      centered_count_next = centered_inc;
      off_count_next      = '0;
      if (centered_inc > CENTER_LIMIT) begin
        centered_count_next = '0;
        if (speed_increment != INC_MAX) begin
          ramped = speed_increment + 11'sd1;
        end
      end
    end else begin
      off_count_next      = off_inc;
      centered_count_next = '0;
      if (off_inc > OFF_LIMIT) begin
        off_count_next = '0;
        if (speed_increment != INC_MIN) begin
          ramped = speed_increment - 11'sd1;
        end
      end
    end
  end

  // near obstacle drops the increment
  assign incr_next = ctl.near ? '0 : ramped;

  // state update once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      centered_count  <= '0;
      off_count       <= '0;
      speed_increment <= '0;
    end else if (step) begin
      centered_count  <= centered_count_next;
      off_count       <= off_count_next;
      speed_increment <= incr_next;
    end
  end

endmodule

`default_nettype wire

[sv/lfpsc_pid.sv]
// pid steering effort on the line position, q16 result
`default_nettype none

module lfpsc_pid
  import lfpsc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     step,
  input  wire logic [POS_W-1:0]         line_position,
  input  wire pid_gains_t               gains,
  output logic signed [EFFORT_W-1:0]    effort
);

  logic signed [INTEG_W-1:0] integral_sum, integral_sum_next;
  logic signed [ERR_W-1:0]   prev_error;
  logic [POS_W-1:0]          pos_c;
  logic signed [ERR_W:0]     err_wide;
  logic signed [ERR_W-1:0]   err;
  logic signed [INTEG_W:0]   integ_raw;
  logic signed [ERR_W:0]     diff;
  logic signed [29:0]        p_term;
  logic signed [32:0]        i_term;
  logic signed [30:0]        d_term;

  // error around the center position
  assign pos_c    = (line_position > POS_MAX) ? POS_MAX : line_position;
  assign err_wide = $signed({1'b0, pos_c}) - POS_CENTER;
  assign err      = err_wide[ERR_W-1:0];

  // integral with reset above the limit and floor saturation
  assign integ_raw = (INTEG_W+1)'(integral_sum) + (INTEG_W+1)'(err);
  always_comb begin
    if (integ_raw > INTEG_RESET_ABOVE) begin
      integral_sum_next = '0;
    end else if (integ_raw < INTEG_MIN) begin
      integral_sum_next = INTEG_MIN[INTEG_W-1:0];
    end else begin
      integral_sum_next = integ_raw[INTEG_W-1:0];
    end
  end

  // derivative
  assign diff = (ERR_W+1)'(err) - (ERR_W+1)'(prev_error);

  // three independent gain products
  assign p_term = $signed({1'b0, gains.gain_p}) * err;
  assign i_term = $signed({1'b0, gains.gain_i}) * integral_sum_next;
  assign d_term = $signed({1'b0, gains.gain_d}) * diff;

  assign effort = EFFORT_W'(p_term) + EFFORT_W'(i_term) + EFFORT_W'(d_term);

  // state update once per processed beat
  always_ff @(posedge clk) begin
    if (rst) begin
      integral_sum <= '0;
      prev_error   <= '0;
    end else if (step) begin
      integral_sum <= integral_sum_next;
      prev_error   <= err;
    end
  end

endmodule

`default_nettype wire

[sv/lfpsc_mix.sv]
// differential drive mixing of base level and pid effort with clamping
`default_nettype none

module lfpsc_mix
  import lfpsc_pkg::*;
(
  input  wire logic [SPEED_W-1:0]        base,
  input  wire logic signed [INC_W-1:0]   incr,
  input  wire logic signed [EFFORT_W-1:0] effort,
  input  wire logic [SPEED_W-1:0]        speed_cap,
  output logic [SPEED_W-1:0]             left_speed,
  output logic [SPEED_W-1:0]             right_speed
);

  logic signed [INC_W:0]   level;
  logic signed [RAW_W-1:0] level_q16;
  logic signed [RAW_W-1:0] raw_left;
  logic signed [RAW_W-1:0] raw_right;

  // base plus increment, scaled to q16
  assign level     = $signed({3'b000, base}) + (INC_W+1)'(incr);
  assign level_q16 = RAW_W'($signed({level, 16'h0000}));

  // left slows with positive effort, right speeds up
  assign raw_left  = level_q16 - RAW_W'(effort);
  assign raw_right = level_q16 + RAW_W'(effort);

  assign left_speed  = clamp_speed(raw_left, speed_cap);
  assign right_speed = clamp_speed(raw_right, speed_cap);

endmodule

`default_nettype wire

[sv/line_follow_pid_speed_control.sv]
// a result beat is held in the input register and then moves on to the result register
// throughput: one beat per cycle while out_ready is high; a stalled result holds the
// input register, and in_ready drops once both registers are full and out_ready is low
// the whole step runs in one pass from the input register to the result register,
// its depth set by the three gain multipliers feeding the effort sum and clamps
// reset: synchronous, clears valids, pid and ramp state, loads register defaults
`default_nettype none

module line_follow_pid_speed_control
  import lfpsc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_beat_t              in_beat,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_beat_t                  out_beat,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_regs_t               cfg;
  logic                    s1_valid;
  in_beat_t                s1_beat;
  logic                    advance;
  logic [THRESH_W-1:0]     sum_r;
  logic [THRESH_W-1:0]     sum_l;
  logic [SENSE_W:0]        pair_r;
  logic [SENSE_W:0]        pair_l;
  ramp_ctl_t               ramp_ctl;
  logic signed [INC_W-1:0] incr_next;
  logic signed [EFFORT_W-1:0] effort;
  logic [SPEED_W-1:0]      base;
  out_beat_t               result;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_THRESH_RIGHT: cfg.thresh_right       <= cfg_data[THRESH_W-1:0];
        REG_THRESH_LEFT:  cfg.thresh_left        <= cfg_data[THRESH_W-1:0];
        REG_GAIN_P:       cfg.gains.gain_p       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_I:       cfg.gains.gain_i       <= cfg_data[GAIN_W-1:0];
        REG_GAIN_D:       cfg.gains.gain_d       <= cfg_data[GAIN_W-1:0];
        REG_CRUISE_SPEED: cfg.cruise_speed       <= cfg_data[SPEED_W-1:0];
        REG_SLOW_SPEED:   cfg.slow_speed         <= cfg_data[SPEED_W-1:0];
        REG_SPEED_CAP:    cfg.speed_cap          <= cfg_data[SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // input register, moves on when the result register is free
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_beat <= in_beat;
    end
  end

  // intersection detect on the two three-sensor sums
  assign sum_r = THRESH_W'(s1_beat.sense_a) + THRESH_W'(s1_beat.sense_b)
               + THRESH_W'(s1_beat.sense_c);
  assign sum_l = THRESH_W'(s1_beat.sense_d) + THRESH_W'(s1_beat.sense_e)
               + THRESH_W'(s1_beat.sense_f);

  // centered when an inner sensor outweighs its two outer neighbors
  assign pair_r = (SENSE_W+1)'(s1_beat.sense_a) + (SENSE_W+1)'(s1_beat.sense_b);
  assign pair_l = (SENSE_W+1)'(s1_beat.sense_e) + (SENSE_W+1)'(s1_beat.sense_f);
  assign ramp_ctl.centered = ((SENSE_W+1)'(s1_beat.sense_c) > pair_r)
                          || ((SENSE_W+1)'(s1_beat.sense_d) > pair_l);
  assign ramp_ctl.near     = s1_beat.near_obstacle;

  lfpsc_ramp u_ramp (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .ctl       (ramp_ctl),
    .incr_next (incr_next)
  );

  lfpsc_pid u_pid (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .line_position (s1_beat.line_position),
    .gains         (cfg.gains),
    .effort        (effort)
  );

  assign base = s1_beat.near_obstacle ? cfg.slow_speed : cfg.cruise_speed;

  lfpsc_mix u_mix (
    .base        (base),
    .incr        (incr_next),
    .effort      (effort),
    .speed_cap   (cfg.speed_cap),
    .left_speed  (result.left_speed),
    .right_speed (result.right_speed)
  );

  assign result.at_intersection = (sum_l > cfg.thresh_left) && (sum_r > cfg.thresh_right);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat <= result;
    end
  end

endmodule

`default_nettype wire

[sv/lfpsc_checker.sv]
// port-level checks for the line follower speed controller, with bind
`default_nettype none

module lfpsc_checker
  import lfpsc_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_beat_t out_beat
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_beat))
    else $error("stalled result beat changed");

  // input only backs up when the output is full and stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled while output could drain");

  // a fresh result comes from an accepted input beat that passed through the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result beat without an accepted input beat");

endmodule

bind line_follow_pid_speed_control lfpsc_checker u_checker (.*);

`default_nettype wire

[dv/line_follow_pid_speed_control_tb.sv]
// testbench for the line follower pid speed controller: directed corners, random phases, ramp walk
`timescale 1ns / 1ps

module line_follow_pid_speed_control_tb;
  import lfpsc_pkg::*;

  // predictor constants
  localparam logic [12:0] POS_TOP     = 13'd5000;
  localparam int          POS_MID     = 1500;
  localparam int          INTEG_CEIL  = 10000;
  localparam int          INTEG_FLOOR = -32768;
  localparam int          RAMP_TOP    = 1023;
  localparam int          RAMP_BOTTOM = -1024;
  localparam logic [3:0]  CENTER_RUNS = 4'd8;
  localparam logic [2:0]  OFF_RUNS    = 3'd4;

  localparam int PHASE_BEATS = 168;
  localparam int CLIMB_BEATS = 200;
  localparam int FALL_BEATS  = 100;
  localparam int STALL_LIMIT = 2000;

  // register fill patterns between phases
  typedef enum int {FILL_KEEP, FILL_ZERO, FILL_ONES, FILL_RANDOM} cfg_fill_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_beat_t              in_beat = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_beat_t             out_beat;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit no_idle = 1'b0;
  int mismatches = 0;
  int quiet_cycles = 0;

  // controller state as predicted
  cfg_regs_t          cfg_shadow;
  logic signed [15:0] integ_acc  = '0;
  logic signed [12:0] last_err   = '0;
  logic signed [10:0] ramp_inc   = '0;
  logic [3:0]         center_run = '0;
  logic [2:0]         off_run    = '0;

  out_beat_t pending_speeds[$];

  line_follow_pid_speed_control uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_beat  (out_beat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // floor a q16 level and clamp it to 0..top
  function automatic logic [SPEED_W-1:0] floor_to_speed(input longint q16,
                                                        input logic [SPEED_W-1:0] top);
    longint whole;
    if (q16 < 0) return '0;
    whole = q16 >>> 16;
    return (whole > longint'(top)) ? top : whole[SPEED_W-1:0];
  endfunction

  // advance ramp and pid by one sample and return the motor speeds it gives
  function automatic out_beat_t steer_step(input in_beat_t s);
    out_beat_t          r;
    logic [11:0]        right_sum, left_sum;
    logic [10:0]        ab_sum, ef_sum;
    logic [12:0]        pos;
    logic [SPEED_W-1:0] base;
    int                 err, acc;
    longint             effort, level;
    right_sum = s.sense_a + s.sense_b + s.sense_c;
    left_sum  = s.sense_d + s.sense_e + s.sense_f;
    ab_sum    = s.sense_a + s.sense_b;
    ef_sum    = s.sense_e + s.sense_f;

    // speed ramp on runs of centered and off-center samples
    if (s.sense_c > ab_sum || s.sense_d > ef_sum) begin
      off_run = '0;
      if (center_run == CENTER_RUNS) begin
        center_run = '0;
        if (ramp_inc < RAMP_TOP) ramp_inc += 1;
      end else begin
        center_run += 1;
      end
    end else begin
      center_run = '0;
      if (off_run == OFF_RUNS) begin
        off_run = '0;
        if (ramp_inc > RAMP_BOTTOM) ramp_inc -= 1;
      end else begin
        off_run += 1;
      end
    end

    // pid on the offset position
    pos = (s.line_position > POS_TOP) ? POS_TOP : s.line_position;
    err = int'(pos) - POS_MID;
    acc = int'(integ_acc) + err;
    if (acc > INTEG_CEIL) acc = 0;
    if (acc < INTEG_FLOOR) acc = INTEG_FLOOR;
    integ_acc = 16'(acc);
    effort = longint'(cfg_shadow.gains.gain_p) * err
           + longint'(cfg_shadow.gains.gain_i) * acc
           + longint'(cfg_shadow.gains.gain_d) * (err - int'(last_err));
    last_err = 13'(err);

    // obstacle mode drops the ramp and selects the slow base
    if (s.near_obstacle) ramp_inc = '0;
    base  = s.near_obstacle ? cfg_shadow.slow_speed : cfg_shadow.cruise_speed;
    level = (longint'(base) + longint'(ramp_inc)) * 65536;

    r.left_speed      = floor_to_speed(level - effort, cfg_shadow.speed_cap);
    r.right_speed     = floor_to_speed(level + effort, cfg_shadow.speed_cap);
    r.at_intersection = (left_sum > cfg_shadow.thresh_left) &&
                        (right_sum > cfg_shadow.thresh_right);
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // check result beats against the oldest prediction, then predict accepted samples
  always @(posedge clk) begin : score
    out_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_speeds.size() == 0) begin
        flag_mismatch("result beat with nothing expected");
      end else begin
        want = pending_speeds.pop_front();
        if (out_beat.left_speed !== want.left_speed)
          flag_mismatch($sformatf("left_speed got %0d want %0d",
                                  out_beat.left_speed, want.left_speed));
        if (out_beat.right_speed !== want.right_speed)
          flag_mismatch($sformatf("right_speed got %0d want %0d",
                                  out_beat.right_speed, want.right_speed));
        if (out_beat.at_intersection !== want.at_intersection)
          flag_mismatch($sformatf("at_intersection got %b want %b",
                                  out_beat.at_intersection, want.at_intersection));
      end
    end
    if (!rst && in_valid && in_ready) pending_speeds.push_back(steer_step(in_beat));
  end

  // result side stalls
  always @(negedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 32);
  end

  // watchdog on cycles with no beat moving
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one sample beat, with random gaps ahead of it
  task automatic send_sample(input in_beat_t s);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < 32) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_beat  <= s;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every predicted result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_THRESH_RIGHT: cfg_shadow.thresh_right = data[THRESH_W-1:0];
      REG_THRESH_LEFT:  cfg_shadow.thresh_left  = data[THRESH_W-1:0];
      REG_GAIN_P:       cfg_shadow.gains.gain_p = data[GAIN_W-1:0];
      REG_GAIN_I:       cfg_shadow.gains.gain_i = data[GAIN_W-1:0];
      REG_GAIN_D:       cfg_shadow.gains.gain_d = data[GAIN_W-1:0];
      REG_CRUISE_SPEED: cfg_shadow.cruise_speed = data[SPEED_W-1:0];
      REG_SLOW_SPEED:   cfg_shadow.slow_speed   = data[SPEED_W-1:0];
      REG_SPEED_CAP:    cfg_shadow.speed_cap    = data[SPEED_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_regs(input cfg_fill_e fill);
    logic [CFG_DATA_W-1:0] data;
    if (fill == FILL_KEEP) return;
    for (int i = 0; i < 8; i++) begin
      case (fill)
        FILL_ZERO: data = '0;
        FILL_ONES: data = '1;
        default: begin
          // mostly in-range values, sometimes the whole data word
          if ($urandom_range(0, 99) < 15) begin
            data = 16'($urandom);
          end else begin
            case (reg_index_t'(i))
              REG_THRESH_RIGHT, REG_THRESH_LEFT: data = 16'($urandom_range(0, 3200));
              REG_GAIN_P, REG_GAIN_I, REG_GAIN_D:
                data = $urandom_range(0, 1) ? 16'($urandom_range(0, 12000)) : 16'($urandom);
              default: data = 16'($urandom_range(0, 511));
            endcase
          end
        end
      endcase
      write_reg(reg_index_t'(i), data);
    end
  endtask

  function automatic in_beat_t corner_sample(input int a, input int b, input int c,
                                             input int d, input int e, input int f,
                                             input int pos, input bit near);
    in_beat_t s;
    s.sense_a       = 10'(a);
    s.sense_b       = 10'(b);
    s.sense_c       = 10'(c);
    s.sense_d       = 10'(d);
    s.sense_e       = 10'(e);
    s.sense_f       = 10'(f);
    s.line_position = 13'(pos);
    s.near_obstacle = near;
    return s;
  endfunction

  // random sample that is centered or off center as asked
  function automatic in_beat_t sample_with(input bit centered, input int lo, input int hi,
                                           input bit near);
    in_beat_t s;
    int       lim;
    s.sense_a = 10'($urandom_range(0, 1023));
    s.sense_b = 10'($urandom_range(0, 1023));
    s.sense_c = 10'($urandom_range(0, 1023));
    s.sense_d = 10'($urandom_range(0, 1023));
    s.sense_e = 10'($urandom_range(0, 1023));
    s.sense_f = 10'($urandom_range(0, 1023));
    if (centered) begin
      if ($urandom_range(0, 1)) begin
        s.sense_a = 10'($urandom_range(0, 400));
        s.sense_b = 10'($urandom_range(0, 400));
        s.sense_c = 10'($urandom_range(int'(s.sense_a) + int'(s.sense_b) + 1, 1023));
      end else begin
        s.sense_e = 10'($urandom_range(0, 400));
        s.sense_f = 10'($urandom_range(0, 400));
        s.sense_d = 10'($urandom_range(int'(s.sense_e) + int'(s.sense_f) + 1, 1023));
      end
    end else begin
      lim = int'(s.sense_a) + int'(s.sense_b);
      s.sense_c = 10'($urandom_range(0, (lim > 1023) ? 1023 : lim));
      lim = int'(s.sense_e) + int'(s.sense_f);
      s.sense_d = 10'($urandom_range(0, (lim > 1023) ? 1023 : lim));
    end
    s.line_position = 13'($urandom_range(lo, hi));
    s.near_obstacle = near;
    return s;
  endfunction

  task automatic test_directed_corners();
    // all dark at the far right: right motor goes negative and clamps to zero
    send_sample(corner_sample(0, 0, 0, 0, 0, 0, 0, 1'b0));
    // all bright at the far left: one motor saturates at max speed
    send_sample(corner_sample(1023, 1023, 1023, 1023, 1023, 1023, 5000, 1'b0));
    // positions past the sensor span read as the far end
    send_sample(corner_sample(7, 9, 900, 3, 2, 1, 5001, 1'b0));
    send_sample(corner_sample(7, 9, 900, 3, 2, 1, 8191, 1'b0));
    send_sample(corner_sample(7, 9, 900, 3, 2, 1, 1500, 1'b0));
    // center sensors just above and equal to their neighbors
    send_sample(corner_sample(100, 200, 301, 0, 0, 0, 1500, 1'b0));
    send_sample(corner_sample(100, 200, 300, 0, 0, 0, 1600, 1'b0));
    send_sample(corner_sample(0, 0, 0, 301, 100, 200, 1400, 1'b0));
    send_sample(corner_sample(0, 0, 0, 300, 100, 200, 1400, 1'b0));
    // obstacle near: slow base, ramp cleared
    send_sample(corner_sample(512, 512, 512, 512, 512, 512, 4096, 1'b1));
    wait_drained();

    // intersection on exact threshold boundaries
    write_reg(REG_THRESH_RIGHT, 16'd3068);
    write_reg(REG_THRESH_LEFT, 16'd3069);
    send_sample(corner_sample(1023, 1023, 1023, 1023, 1023, 1023, 2500, 1'b0));
    wait_drained();
    write_reg(REG_THRESH_LEFT, 16'd3068);
    send_sample(corner_sample(1023, 1023, 1023, 1023, 1023, 1023, 2500, 1'b0));
    wait_drained();
    write_reg(REG_THRESH_RIGHT, 16'd0);
    write_reg(REG_THRESH_LEFT, 16'd0);
    send_sample(corner_sample(1, 0, 0, 0, 0, 1, 1000, 1'b0));
    send_sample(corner_sample(0, 0, 0, 5, 5, 5, 1000, 1'b0));
    wait_drained();
  endtask

  task automatic test_random_phases();
    int       run_left, band_left, lo, hi;
    bit       centered;
    in_beat_t s;
    run_left  = 0;
    band_left = 0;
    lo        = 0;
    hi        = 5000;
    centered  = 1'b0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       load_regs(FILL_KEEP);
        1:       load_regs(FILL_ZERO);
        2:       load_regs(FILL_ONES);
        default: load_regs(FILL_RANDOM);
      endcase
      no_idle = (phase == 5);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        if ($urandom_range(0, 99) < 10) begin
          // noise: any field value at all
          s = sample_with($urandom_range(0, 1), 0, 8191, $urandom_range(0, 1));
          s.sense_c = 10'($urandom_range(0, 1023));
          s.sense_d = 10'($urandom_range(0, 1023));
        end else begin
          // position bands held long enough to wind the integral both ways
          if (band_left == 0) begin
            band_left = $urandom_range(10, 60);
            case ($urandom_range(0, 4))
              0:       begin lo = 0;    hi = 800;  end
              1:       begin lo = 1000; hi = 2000; end
              2:       begin lo = 3500; hi = 5000; end
              3:       begin lo = 0;    hi = 5000; end
              default: begin lo = 5001; hi = 8191; end
            endcase
          end
          // alternating runs of centered and off-center samples
          if (run_left == 0) begin
            centered = !centered;
            run_left = centered ? $urandom_range(1, 14) : $urandom_range(1, 7);
          end
          s = sample_with(centered, lo, hi, $urandom_range(0, 99) < 6);
          band_left--;
          run_left--;
        end
        send_sample(s);
        if (i == PHASE_BEATS / 2) wait_drained();
      end
      wait_drained();
    end
    no_idle = 1'b0;
  endtask

  // walk the ramp up and below zero; gain_p near one with the line near center
  // keeps both motors off their clamps so the increment shows
  task automatic test_increment_walk();
    write_reg(REG_GAIN_P, 16'hFFFF);
    write_reg(REG_GAIN_I, 16'd0);
    write_reg(REG_GAIN_D, 16'd0);
    write_reg(REG_CRUISE_SPEED, 16'd256);
    write_reg(REG_SLOW_SPEED, 16'd0);
    write_reg(REG_SPEED_CAP, 16'd511);
    send_sample(sample_with(1'b0, 1490, 1510, 1'b1));

    // climb with no idling at all
    no_idle = 1'b1;
    repeat (CLIMB_BEATS) send_sample(sample_with(1'b1, 1490, 1510, 1'b0));
    no_idle = 1'b0;
    repeat (30) send_sample(sample_with(1'b0, 1490, 1510, 1'b0));
    send_sample(sample_with(1'b0, 1480, 1520, 1'b1));

    // fall below zero, then step back up
    repeat (FALL_BEATS) send_sample(sample_with(1'b0, 1480, 1520, 1'b0));
    repeat (60) send_sample(sample_with(1'b1, 1480, 1520, 1'b0));
    wait_drained();
  endtask

  initial begin
    cfg_shadow = '{thresh_right: 12'd4095, thresh_left: 12'd4095,
                   gains: '{gain_p: 16'd5243, gain_i: 16'd7, gain_d: 16'd24576},
                   cruise_speed: 9'd300, slow_speed: 9'd100, speed_cap: 9'd420};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_random_phases();
    test_increment_walk();
    wait_drained();

    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
